### hdl/autorange_ac_level_meter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the autorange AC level meter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AUTORANGE_AC_LEVEL_METER_ASSERT_SVH
`define AUTORANGE_AC_LEVEL_METER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define ARALM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define ARALM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARALM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARALM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/aralm_pkg.sv
// ----------------------------------------------------------------------------
// aralm_pkg
// Types, widths and constants of the autorange AC level meter.
// ----------------------------------------------------------------------------
package aralm_pkg;

    // window and sample format
    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 12;
    localparam int SAMPLE_W     = 12;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = SLOT_W + SAMPLE_BITS;
    localparam int SUM_MAX      = WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1);

    // mean to centi-mV: sum * 330000 / (depth << bits), depth a power of two
    localparam int FULL_SCALE   = 330000;
    localparam int FS_W         = 19;
    localparam int DEN_SHIFT    = SLOT_W + SAMPLE_BITS;
    localparam int DET_PROD_W   = SUM_W + FS_W;
    localparam int DET_W        = 19;

    // calibration
    localparam int SLOPE_W      = 18;
    localparam int OFFS_W       = 32;
    localparam int AMP_W        = 20;
    localparam int MUL_W        = DET_W + SLOPE_W;
    localparam int CAL_W        = MUL_W + 1;
    localparam int Q_FRAC       = 16;
    localparam logic [AMP_W-1:0] AMP_LIMIT = '1;

    // register file
    localparam int THR_W        = 12;
    localparam int REG_IDX_W    = 3;
    localparam int APB_AW       = REG_IDX_W + 2;
    localparam int APB_DW       = 32;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_THR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ON_BELOW    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFF_ABOVE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AMP_SLOPE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AMP_OFFSET  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIR_SLOPE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DIR_OFFSET  = 3'd6;

    localparam logic [THR_W-1:0]   RST_FIRST_THR  = 12'd300;
    localparam logic [AMP_W-1:0]   RST_ON_BELOW   = 20'd10000;
    localparam logic [AMP_W-1:0]   RST_OFF_ABOVE  = 20'd13000;
    localparam logic [SLOPE_W-1:0] RST_AMP_SLOPE  = 18'd9240;
    localparam logic [OFFS_W-1:0]  RST_AMP_OFFSET = 32'd8266975;
    localparam logic [SLOPE_W-1:0] RST_DIR_SLOPE  = 18'd93923;
    localparam logic [OFFS_W-1:0]  RST_DIR_OFFSET = 32'd98868265;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCALE,
        ST_CAL,
        ST_EMIT
    } t_state;

endpackage

### hdl/aralm_ifs.sv
// ----------------------------------------------------------------------------
// aralm interfaces
// Valid/ready channels for ADC sample words and meter result words.
// ----------------------------------------------------------------------------
interface aralm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [aralm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface aralm_result_if;
    logic                          valid;
    logic                          ready;
    logic [aralm_pkg::DET_W-1:0]   detector_centi_mv;
    logic [aralm_pkg::AMP_W-1:0]   input_centi_mvpp;
    logic                          gain_used;
    logic                          gain_next;

    modport source (output valid, output detector_centi_mv, output input_centi_mvpp,
                    output gain_used, output gain_next, input ready);
    modport sink   (input valid, input detector_centi_mv, input input_centi_mvpp,
                    input gain_used, input gain_next, output ready);
endinterface

### hdl/autorange_ac_level_meter.sv
// ----------------------------------------------------------------------------
// autorange_ac_level_meter
// Moving average of detector samples, calibration to input amplitude and
// hysteresis control of the gain relay.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake      word
//  i_sample   in   valid/ready    sample[11:0]
//  o_result   out  valid/ready    detector_centi_mv, input_centi_mvpp,
//                                 gain_used, gain_next
//  apb        in   psel/penable   7 registers at 4*i, pready tied high
//
//  One word at a time: accept, ring update, scale multiply, calibration
//  multiply, emit; the first word skips the ring update. A new sample word
//  is taken only after the last one has been emitted.
//  The next sample is taken while a result still waits in the output register;
//  emit stalls only when that register is still full.
//  Reset is synchronous; the ring needs no clearing pass: a fill flag makes
//  slots not yet written read as zero.
//
module autorange_ac_level_meter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    aralm_sample_if.sink                     i_sample,
    aralm_result_if.source                   o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aralm_pkg::APB_AW-1:0]     paddr,
    input  logic [aralm_pkg::APB_DW-1:0]     pwdata,
    output logic [aralm_pkg::APB_DW-1:0]     prdata,
    output logic                             pready
);

    `include "autorange_ac_level_meter_assert.svh"

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    logic [aralm_pkg::THR_W-1:0]   r_first_thr;
    logic [aralm_pkg::AMP_W-1:0]   r_on_below;
    logic [aralm_pkg::AMP_W-1:0]   r_off_above;
    logic [aralm_pkg::SLOPE_W-1:0] r_amp_slope;
    logic [aralm_pkg::OFFS_W-1:0]  r_amp_offset;
    logic [aralm_pkg::SLOPE_W-1:0] r_dir_slope;
    logic [aralm_pkg::OFFS_W-1:0]  r_dir_offset;

    logic                             cfg_wr;
    logic [aralm_pkg::REG_IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[aralm_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_thr  <= aralm_pkg::RST_FIRST_THR;
            r_on_below   <= aralm_pkg::RST_ON_BELOW;
            r_off_above  <= aralm_pkg::RST_OFF_ABOVE;
            r_amp_slope  <= aralm_pkg::RST_AMP_SLOPE;
            r_amp_offset <= aralm_pkg::RST_AMP_OFFSET;
            r_dir_slope  <= aralm_pkg::RST_DIR_SLOPE;
            r_dir_offset <= aralm_pkg::RST_DIR_OFFSET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                aralm_pkg::REG_FIRST_THR:  r_first_thr  <= pwdata[aralm_pkg::THR_W-1:0];
                aralm_pkg::REG_ON_BELOW:   r_on_below   <= pwdata[aralm_pkg::AMP_W-1:0];
                aralm_pkg::REG_OFF_ABOVE:  r_off_above  <= pwdata[aralm_pkg::AMP_W-1:0];
                aralm_pkg::REG_AMP_SLOPE:  r_amp_slope  <= pwdata[aralm_pkg::SLOPE_W-1:0];
                aralm_pkg::REG_AMP_OFFSET: r_amp_offset <= pwdata[aralm_pkg::OFFS_W-1:0];
                aralm_pkg::REG_DIR_SLOPE:  r_dir_slope  <= pwdata[aralm_pkg::SLOPE_W-1:0];
                aralm_pkg::REG_DIR_OFFSET: r_dir_offset <= pwdata[aralm_pkg::OFFS_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            aralm_pkg::REG_FIRST_THR:  prdata = aralm_pkg::APB_DW'(r_first_thr);
            aralm_pkg::REG_ON_BELOW:   prdata = aralm_pkg::APB_DW'(r_on_below);
            aralm_pkg::REG_OFF_ABOVE:  prdata = aralm_pkg::APB_DW'(r_off_above);
            aralm_pkg::REG_AMP_SLOPE:  prdata = aralm_pkg::APB_DW'(r_amp_slope);
            aralm_pkg::REG_AMP_OFFSET: prdata = r_amp_offset;
            aralm_pkg::REG_DIR_SLOPE:  prdata = aralm_pkg::APB_DW'(r_dir_slope);
            aralm_pkg::REG_DIR_OFFSET: prdata = r_dir_offset;
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    aralm_pkg::t_state r_state, n_state;

    logic in_acc;      // sample word taken this edge
    logic ring_rd;     // read old slot
    logic ring_upd;    // write slot, update sum
    logic do_scale;
    logic do_cal;
    logic do_emit;
    logic out_free;
    logic r_out_valid;

    assign out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aralm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic r_seen_first;

    always_comb begin
        n_state         = r_state;
        i_sample.ready  = 1'b0;
        ring_rd         = 1'b0;
        ring_upd        = 1'b0;
        do_scale        = 1'b0;
        do_cal          = 1'b0;
        do_emit         = 1'b0;
        unique case (r_state)
            aralm_pkg::ST_IDLE: begin
                i_sample.ready = 1'b1;
                if (i_sample.valid) begin
                    // first word after reset only picks the range
                    ring_rd = r_seen_first;
                    n_state = r_seen_first ? aralm_pkg::ST_UPDATE : aralm_pkg::ST_SCALE;
                end
            end
            aralm_pkg::ST_UPDATE: begin
                ring_upd = 1'b1;
                n_state  = aralm_pkg::ST_SCALE;
            end
            aralm_pkg::ST_SCALE: begin
                do_scale = 1'b1;
                n_state  = aralm_pkg::ST_CAL;
            end
            aralm_pkg::ST_CAL: begin
                do_cal  = 1'b1;
                n_state = aralm_pkg::ST_EMIT;
            end
            aralm_pkg::ST_EMIT: begin
                if (out_free) begin
                    do_emit = 1'b1;
                    n_state = aralm_pkg::ST_IDLE;
                end
            end
            default: n_state = aralm_pkg::ST_IDLE;
        endcase
    end

    assign in_acc = i_sample.valid & i_sample.ready;

    // ------------------------------------------------------------------
    // sample ring: one read port, one write port, registered read
    // ------------------------------------------------------------------
    logic [aralm_pkg::SAMPLE_BITS-1:0] r_ring [aralm_pkg::WINDOW_DEPTH];
    logic [aralm_pkg::SAMPLE_BITS-1:0] r_rd_data;
    logic [aralm_pkg::SAMPLE_BITS-1:0] r_sample;
    logic [aralm_pkg::SLOT_W-1:0]      r_slot;
    logic                              r_full;   // ring has wrapped once
    logic [aralm_pkg::SUM_W-1:0]       r_sum;
    logic [aralm_pkg::SAMPLE_BITS-1:0] old_sample;
    logic [aralm_pkg::SAMPLE_BITS-1:0] new_sample;
    logic                              slot_last;

    assign new_sample = i_sample.sample[aralm_pkg::SAMPLE_BITS-1:0];
    assign old_sample = r_full ? r_rd_data : '0;
    assign slot_last  = (r_slot == aralm_pkg::SLOT_W'(aralm_pkg::WINDOW_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (ring_rd) begin
            r_rd_data <= r_ring[r_slot];
        end
        if (ring_upd) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    // read and write of a slot are in separate states, one word in flight:
    // no overlap on the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (ring_upd) begin
            r_slot <= slot_last ? '0 : r_slot + 1'b1;
            r_full <= r_full | slot_last;
            r_sum  <= r_sum - aralm_pkg::SUM_W'(old_sample)
                            + aralm_pkg::SUM_W'(r_sample);
        end
    end

    // ------------------------------------------------------------------
    // gain range
    // ------------------------------------------------------------------
    logic r_gain_on;
    logic r_first_item;   // current word is the range-setting one

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= new_sample;
        end
    end

    logic [aralm_pkg::AMP_W-1:0] amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_on    <= 1'b0;
            r_seen_first <= 1'b0;
            r_first_item <= 1'b0;
        end else if (in_acc) begin
            r_first_item <= !r_seen_first;
            if (!r_seen_first) begin
                r_seen_first <= 1'b1;
                r_gain_on    <= (new_sample < r_first_thr);
            end
        end else if (do_emit && !r_first_item) begin
            // on test wins when thresholds overlap
            if (amp < r_on_below) begin
                r_gain_on <= 1'b1;
            end else if (amp > r_off_above) begin
                r_gain_on <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath: scale multiply, calibration multiply, offset and saturate
    // ------------------------------------------------------------------
    logic [aralm_pkg::DET_PROD_W-1:0] det_prod;
    logic [aralm_pkg::DET_W-1:0]      r_det;
    logic [aralm_pkg::SLOPE_W-1:0]    slope;
    logic [aralm_pkg::OFFS_W-1:0]     offs;
    logic [aralm_pkg::MUL_W-1:0]      r_mul;
    logic [aralm_pkg::CAL_W-1:0]      cal_sum;
    logic [aralm_pkg::CAL_W-aralm_pkg::Q_FRAC-1:0] cal_int;

    assign det_prod = aralm_pkg::DET_PROD_W'(r_sum)
                    * aralm_pkg::DET_PROD_W'(aralm_pkg::FULL_SCALE);
    assign slope    = r_gain_on ? r_amp_slope  : r_dir_slope;
    assign offs     = r_gain_on ? r_amp_offset : r_dir_offset;
    assign cal_sum  = aralm_pkg::CAL_W'(r_mul) + aralm_pkg::CAL_W'(offs);
    assign cal_int  = cal_sum[aralm_pkg::CAL_W-1:aralm_pkg::Q_FRAC];
    assign amp      = (cal_int > (aralm_pkg::CAL_W-aralm_pkg::Q_FRAC)'(aralm_pkg::AMP_LIMIT))
                    ? aralm_pkg::AMP_LIMIT : cal_int[aralm_pkg::AMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (do_scale) begin
            r_det <= aralm_pkg::DET_W'(det_prod >> aralm_pkg::DEN_SHIFT);
        end
        if (do_cal) begin
            r_mul <= aralm_pkg::MUL_W'(r_det) * aralm_pkg::MUL_W'(slope);
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [aralm_pkg::DET_W-1:0] r_out_det;
    logic [aralm_pkg::AMP_W-1:0] r_out_amp;
    logic                        r_out_used;
    logic                        r_out_next;
    logic                        gain_after;

    // relay drive after this word
    assign gain_after = r_first_item     ? r_gain_on :
                        (amp < r_on_below) ? 1'b1 :
                        (amp > r_off_above) ? 1'b0 : r_gain_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_det  <= r_det;
            r_out_amp  <= amp;
            r_out_used <= r_gain_on;
            r_out_next <= gain_after;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.detector_centi_mv = r_out_det;
    assign o_result.input_centi_mvpp  = r_out_amp;
    assign o_result.gain_used         = r_out_used;
    assign o_result.gain_next         = r_out_next;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ARALM_ASSERT(a_sum_bound, i_clk, i_rst_n,
        r_sum <= aralm_pkg::SUM_W'(aralm_pkg::SUM_MAX), "running sum out of range")
    `ARALM_ASSERT(a_first_skips_ring, i_clk, i_rst_n,
        (in_acc && !r_seen_first) |=> (r_slot == $past(r_slot)), "first word touched ring")
    `ARALM_ASSERT(a_rise_from_emit, i_clk, i_rst_n,
        $rose(o_result.valid) |-> $past(r_state == aralm_pkg::ST_EMIT), "result without emit")
    `ARALM_ASSERT_ALWAYS(a_reset_clears_out, i_clk,
        !i_rst_n |=> !o_result.valid, "result valid after reset")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: autorange AC level meter testbench
// Streams ADC sample words through the meter under several register settings
// and checks every reading word against an in-bench model of the ring
// average, the range calibration and the relay hysteresis.
// ----------------------------------------------------------------------------
module tb;
    import aralm_pkg::*;

    // no-handshake cycles before the run is declared hung
    localparam int LIMIT_CYCLES = 5000;
    // register settings in the run, and sample words under each
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 225;
    // cycles the block may still be busy after the last reading word
    localparam int SETTLE_CYCLES = 8;
    // words of the opening directed sequence
    localparam int OPENING_WORDS = 18;

    // index past the register map, writes to it must be dropped
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // mean to centi-mV: sum * 330000 / (64 << 12)
    localparam longint unsigned CENTI_MV_SPAN = 330000;
    localparam int              AVG_SHIFT     = 18;
    localparam int              CAL_SHIFT     = 16;
    localparam longint unsigned AMP_CEIL      = 1048575;

    typedef struct packed {
        logic [DET_W-1:0] det;
        logic [AMP_W-1:0] amp;
        logic             used;
        logic             next;
    } t_reading;

    // ------------------------------------------------------------------------
    // Level meter model: window ring, running sum, relay state and registers.
    // take_sample() predicts the reading word of each accepted sample word,
    // check_reading() compares an accepted reading word with the oldest one.
    // ------------------------------------------------------------------------
    class level_meter_model;
        logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
        logic [SLOT_W-1:0]   slot;
        logic [SUM_W-1:0]    sum;
        logic                gain_on;
        logic                seen_first;

        logic [THR_W-1:0]    first_thr;
        logic [AMP_W-1:0]    on_below;
        logic [AMP_W-1:0]    off_above;
        logic [SLOPE_W-1:0]  amp_slope;
        logic [OFFS_W-1:0]   amp_offs;
        logic [SLOPE_W-1:0]  dir_slope;
        logic [OFFS_W-1:0]   dir_offs;

        t_reading            pending_readings [$];
        int                  errors;
        int                  taken;

        function new();
            foreach (ring[k]) ring[k] = '0;
            slot       = '0;
            sum        = '0;
            gain_on    = 1'b0;
            seen_first = 1'b0;
            first_thr  = 12'd300;
            on_below   = 20'd10000;
            off_above  = 20'd13000;
            amp_slope  = 18'd9240;
            amp_offs   = 32'd8266975;
            dir_slope  = 18'd93923;
            dir_offs   = 32'd98868265;
            errors     = 0;
            taken      = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_FIRST_THR:  first_thr = val[THR_W-1:0];
                REG_ON_BELOW:   on_below  = val[AMP_W-1:0];
                REG_OFF_ABOVE:  off_above = val[AMP_W-1:0];
                REG_AMP_SLOPE:  amp_slope = val[SLOPE_W-1:0];
                REG_AMP_OFFSET: amp_offs  = val[OFFS_W-1:0];
                REG_DIR_SLOPE:  dir_slope = val[SLOPE_W-1:0];
                REG_DIR_OFFSET: dir_offs  = val[OFFS_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] s);
            t_reading        r;
            bit              first;
            longint unsigned det;
            longint unsigned amp;
            longint unsigned slope;
            longint unsigned offs;

            first = !seen_first;
            if (first) begin
                // first word only picks the range from the raw value
                seen_first = 1'b1;
                gain_on    = (s < first_thr);
            end else begin
                sum        = sum - ring[slot] + s;
                ring[slot] = s;
                slot       = slot + 1'b1;
            end
            r.used = gain_on;

            det   = sum;
            det   = (det * CENTI_MV_SPAN) >> AVG_SHIFT;
            slope = gain_on ? amp_slope : dir_slope;
            offs  = gain_on ? amp_offs : dir_offs;
            amp   = (det * slope + offs) >> CAL_SHIFT;
            if (amp > AMP_CEIL) amp = AMP_CEIL;

            // hysteresis on the saturated amplitude, on test wins
            if (!first) begin
                if (amp < on_below)
                    gain_on = 1'b1;
                else if (amp > off_above)
                    gain_on = 1'b0;
            end

            r.det  = det[DET_W-1:0];
            r.amp  = amp[AMP_W-1:0];
            r.next = gain_on;
            pending_readings.push_back(r);
            taken++;
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_reading(t_reading got);
            t_reading want;
            if (pending_readings.size() == 0) begin
                report($sformatf("reading word with none due (det %0d amp %0d)",
                                 got.det, got.amp));
                return;
            end
            want = pending_readings.pop_front();
            if (got.det !== want.det)
                report($sformatf("detector_centi_mv got %0d want %0d", got.det, want.det));
            if (got.amp !== want.amp)
                report($sformatf("input_centi_mvpp got %0d want %0d", got.amp, want.amp));
            if (got.used !== want.used)
                report($sformatf("gain_used got %0b want %0b", got.used, want.used));
            if (got.next !== want.next)
                report($sformatf("gain_next got %0b want %0b", got.next, want.next));
        endtask

        function int pending();
            return pending_readings.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and channels
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    aralm_sample_if sample_ch ();
    aralm_result_if result_ch ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    autorange_ac_level_meter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    level_meter_model meter;

    // idle-free stretches on either side, redrawn per run / per 40 readings
    bit steady_tx  = 1'b0;
    bit steady_rx  = 1'b0;
    int n_checked  = 0;
    int n_settings = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One APB write: setup then access. psel stays high across back-to-back
    // writes; the caller drops it after the last one.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        meter.set_reg(idx, val);
    endtask

    // One sample word. Valid stays high into the next word when no gap is
    // drawn, so it is never dropped and raised in the same step.
    task automatic send_word(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        meter.take_sample(s);
    endtask

    // Stop sending, let every reading word out, then give the block time to
    // go idle before registers are touched or the run ends.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (meter.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register setting of each phase. Zero keeps the reset values.
    task automatic configure(input int p);
        logic [APB_DW-1:0] thr, on_b, off_a, a_sl, a_of, d_sl, d_of;
        int                span;
        case (p)
            1: begin
                // anything the fields allow
                thr   = $urandom_range(0, 4095);
                on_b  = $urandom_range(0, 1048575);
                off_a = $urandom_range(0, 1048575);
                a_sl  = $urandom_range(0, 262143);
                a_of  = $urandom;
                d_sl  = $urandom_range(0, 262143);
                d_of  = $urandom;
            end
            2: begin
                // full slopes and offsets: amplitude saturates at the ceiling for high levels
                thr   = 0;
                on_b  = $urandom_range(0, 1048575);
                off_a = $urandom_range(0, 1048575);
                a_sl  = 262143;
                a_of  = 32'hFFFF_FFFF;
                d_sl  = 262143;
                d_of  = 32'hFFFF_FFFF;
            end
            3: begin
                // all zero: amplitude 0, neither test fires, relay holds
                thr = 0; on_b = 0; off_a = 0;
                a_sl = 0; a_of = 0; d_sl = 0; d_of = 0;
            end
            4: begin
                // on threshold above off threshold: on test must win
                on_b  = $urandom_range(13000, 200000);
                off_a = $urandom_range(0, 12000);
                thr   = $urandom_range(0, 4095);
                a_sl  = 9240;
                a_of  = 8266975;
                d_sl  = 93923;
                d_of  = 98868265;
            end
            5: begin
                // top of every threshold, steep slopes, no offset
                thr   = 4095;
                on_b  = 1048575;
                off_a = 1048575;
                a_sl  = 262143;
                a_of  = 0;
                d_sl  = 262143;
                d_of  = 0;
            end
            default: begin
                // near the nominal calibration, a hysteresis band that the
                // sample runs cross in both directions
                span  = $urandom_range(0, 6000);
                on_b  = $urandom_range(5000, 12000);
                off_a = on_b + span;
                thr   = $urandom_range(0, 4095);
                a_sl  = 9240 + $urandom_range(0, 2000) - 1000;
                a_of  = 8266975 + $urandom_range(0, 200000) - 100000;
                d_sl  = 93923 + $urandom_range(0, 20000) - 10000;
                d_of  = 98868265 + $urandom_range(0, 2000000) - 1000000;
            end
        endcase
        apb_write(REG_FIRST_THR, thr);
        apb_write(REG_ON_BELOW, on_b);
        apb_write(REG_OFF_ABOVE, off_a);
        apb_write(REG_AMP_SLOPE, a_sl);
        apb_write(REG_AMP_OFFSET, a_of);
        apb_write(REG_DIR_SLOPE, d_sl);
        apb_write(REG_DIR_OFFSET, d_of);
        // a write past the map must change nothing
        if (p == 1) apb_write(REG_UNMAPPED, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    // Random sample words. Mostly runs around one level, some long enough to fill
    // the window and walk the average through the relay thresholds; the rest
    // is full-range noise and rail-to-rail jumps.
    task automatic run_phase(input int words);
        int left, run, mode, level, v;
        left = words;
        while (left > 0) begin
            mode  = $urandom_range(0, 9);
            run   = (mode < 6) ? $urandom_range(20, 100) : $urandom_range(5, 30);
            if (run > left) run = left;
            level = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 4095);
            steady_tx = ($urandom_range(0, 3) == 0);
            repeat (run) begin
                if (mode < 6) begin
                    v = level + $urandom_range(0, 16) - 8;
                    if (v < 0) v = 0;
                    if (v > 4095) v = 4095;
                end else if (mode < 9) begin
                    v = $urandom_range(0, 4095);
                end else begin
                    v = $urandom_range(0, 1) ? 4095 : 0;
                end
                send_word(v[SAMPLE_W-1:0]);
            end
            left -= run;
        end
    endtask

    // ------------------------------------------------------------------------
    // Reading sink: random stalls, one check per accepted reading word.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (n_checked % 40 == 0) steady_rx = ($urandom_range(0, 3) == 0);
            stall = steady_rx ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
            meter.check_reading('{det:  result_ch.detector_centi_mv,
                                  amp:  result_ch.input_centi_mvpp,
                                  used: result_ch.gain_used,
                                  next: result_ch.gain_next});
            n_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no word moving on either channel.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < LIMIT_CYCLES) @(posedge i_clk);
        $display("tb: timeout, %0d readings still due", meter.pending());
        $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [SAMPLE_W-1:0] opening [OPENING_WORDS];
        int                  p;

        // first word 0 sits below the reset raw threshold: gain on at once,
        // and it must not land in the ring; then rails and bit patterns,
        // and the two values on either side of the raw threshold
        opening = '{12'd0, 12'hFFF, 12'h000, 12'hFFF, 12'hFFF, 12'hAAA,
                    12'h555, 12'h800, 12'h7FF, 12'h001, 12'hFFE, 12'd299,
                    12'd300, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'hFFF};

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        meter = new();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values
        foreach (opening[k]) send_word(opening[k]);
        run_phase(PHASE_WORDS - OPENING_WORDS);

        for (p = 1; p < PHASES; p++) begin
            settle();
            configure(p);
            run_phase(PHASE_WORDS);
        end
        settle();

        $display("tb: %0d sample words sent, %0d readings checked", meter.taken, n_checked);
        $display("tb: %0d register settings after reset, %0d mismatches",
                 n_settings, meter.errors);
        if (meter.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
